[hw/rtl/trwq_pkg.sv]
// ----------------------------------------------------------------------------
// trwq_pkg: shared types and constants for the ready/wait task queues
// Sizes of both lists, field widths, status codes, sequencer states and
// the record handed from the list engine to the output stage.
// ----------------------------------------------------------------------------
package trwq_pkg;

    // list sizes
    localparam int READY_DEPTH = 16;
    localparam int WAIT_DEPTH  = 16;

    // field widths
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int EV_W      = 8;
    localparam int CNT_OUT_W = 5;

    // derived index and count widths
    localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int RCNT_W = $clog2(READY_DEPTH + 1);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

    // action codes
    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_SUSPEND = 1'b1;

    // event code meaning "ready now"
    localparam logic [EV_W-1:0] EV_READY = '0;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_READY_FULL   = 2'd1,
        ST_WAIT_FULL    = 2'd2,
        ST_NONE_RUNNING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_RD,
        ENG_CMP,
        ENG_PLACE,
        ENG_HEAD_LD,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } ready_entry_t;

    typedef struct packed {
        status_t               status;
        logic                  running_valid;
        logic [ID_W-1:0]       running_id;
        logic [PRIO_W-1:0]     running_priority;
        logic [CNT_OUT_W-1:0]  ready_count;
        logic [CNT_OUT_W-1:0]  waiting_count;
    } trwq_result_t;

endpackage

[hw/rtl/trwq_ram.sv]
// ----------------------------------------------------------------------------
// trwq_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module trwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/trwq_engine.sv]
// ----------------------------------------------------------------------------
// trwq_engine: list sequencer for the ready and waiting lists
// The ready list sits in a circular memory sorted by priority; inserts walk
// from the tail one entry at a time through a shared compare, pops move the
// head pointer. Waiting-list entries never reach the ports, so only the
// waiting-list length is kept.
// ----------------------------------------------------------------------------
module trwq_engine
    import trwq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_action,
    input  logic [ID_W-1:0]   req_id,
    input  logic [PRIO_W-1:0] req_prio,
    input  logic [EV_W-1:0]   req_ev,
    output logic              busy,
    output logic              result_valid,
    input  logic              result_taken,
    output trwq_result_t      result
);

    eng_state_t         state_reg, state_next;
    logic [RIDX_W-1:0]  rbase_reg, rbase_next;
    logic [RCNT_W-1:0]  rlen_reg, rlen_next;
    logic [WCNT_W-1:0]  wlen_reg, wlen_next;
    logic [RCNT_W-1:0]  k_reg, k_next;
    status_t            status_reg, status_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [ID_W-1:0]    head_id_reg, head_id_next;
    logic [PRIO_W-1:0]  head_prio_reg, head_prio_next;

    logic               rwr_en;
    logic [RIDX_W-1:0]  rwr_addr;
    ready_entry_t       rwr_data;
    logic [RIDX_W-1:0]  rrd_addr;
    ready_entry_t       rrd_data;
    logic               entry_later;
    logic               ready_full;
    logic               wait_full;

    // logical list position to physical memory address
    function automatic logic [RIDX_W-1:0] ready_addr(
        input logic [RIDX_W-1:0] base,
        input logic [RCNT_W-1:0] pos
    );
        logic [RCNT_W:0] sum;
        sum = (RCNT_W+1)'(base) + (RCNT_W+1)'(pos);
        if (sum >= (RCNT_W+1)'(READY_DEPTH))
        begin
            sum = sum - (RCNT_W+1)'(READY_DEPTH);
        end
        return sum[RIDX_W-1:0];
    endfunction

    // ready list memory
    trwq_ram #(
        .WIDTH ($bits(ready_entry_t)),
        .DEPTH (READY_DEPTH)
    ) u_ready_ram (
        .clk     (clk),
        .wr_en   (rwr_en),
        .wr_addr (rwr_addr),
        .wr_data (rwr_data),
        .rd_addr (rrd_addr),
        .rd_data (rrd_data)
    );

    // shared compare: stored entry ranks after the new task
    assign entry_later = (rrd_data.prio > prio_reg);
    assign ready_full  = (rlen_reg >= RCNT_W'(READY_DEPTH));
    assign wait_full   = (wlen_reg >= WCNT_W'(WAIT_DEPTH));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ENG_IDLE;
            rbase_reg  <= '0;
            rlen_reg   <= '0;
            wlen_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            rbase_reg  <= rbase_next;
            rlen_reg   <= rlen_next;
            wlen_reg   <= wlen_next;
            status_reg <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        head_id_reg   <= head_id_next;
        head_prio_reg <= head_prio_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        rbase_next     = rbase_reg;
        rlen_next      = rlen_reg;
        wlen_next      = wlen_reg;
        status_next    = status_reg;
        k_next         = k_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        head_id_next   = head_id_reg;
        head_prio_next = head_prio_reg;
        rwr_en         = 1'b0;
        rwr_addr       = ready_addr(rbase_reg, k_reg);
        rwr_data       = '{id: id_reg, prio: prio_reg};
        rrd_addr       = ready_addr(rbase_reg, k_reg - RCNT_W'(1));

        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    id_next     = req_id;
                    prio_next   = req_prio;
                    k_next      = rlen_reg;
                    status_next = ST_OK;
                    state_next  = ENG_DONE;
                    if (req_action == ACT_ADD)
                    begin
                        if (req_ev == EV_READY)
                        begin
                            if (ready_full)
                            begin
                                status_next = ST_READY_FULL;
                            end
                            else if (rlen_reg == '0)
                            begin
                                state_next = ENG_PLACE;
                            end
                            else
                            begin
                                state_next = ENG_RD;
                            end
                        end
                        else if (wait_full)
                        begin
                            status_next = ST_WAIT_FULL;
                        end
                        else
                        begin
                            wlen_next = wlen_reg + WCNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (rlen_reg == '0)
                        begin
                            status_next = ST_NONE_RUNNING;
                        end
                        else if (wait_full)
                        begin
                            status_next = ST_WAIT_FULL;
                        end
                        else
                        begin
                            // running task moves to the waiting list
                            wlen_next  = wlen_reg + WCNT_W'(1);
                            rbase_next = ready_addr(rbase_reg, RCNT_W'(1));
                            rlen_next  = rlen_reg - RCNT_W'(1);
                            rrd_addr   = ready_addr(rbase_reg, RCNT_W'(1));
                            if (rlen_reg > RCNT_W'(1))
                            begin
                                state_next = ENG_HEAD_LD;
                            end
                        end
                    end
                end
            end

            ENG_RD:
            begin
                // read entry k-1, data arrives next cycle
                state_next = ENG_CMP;
            end

            ENG_CMP:
            begin
                rwr_en = 1'b1;
                if (entry_later)
                begin
                    // shift the entry one place toward the tail
                    rwr_data = rrd_data;
                    k_next   = k_reg - RCNT_W'(1);
                    if (k_reg == RCNT_W'(1))
                    begin
                        state_next = ENG_PLACE;
                    end
                    else
                    begin
                        state_next = ENG_RD;
                    end
                end
                else
                begin
                    rlen_next  = rlen_reg + RCNT_W'(1);
                    state_next = ENG_DONE;
                end
            end

            ENG_PLACE:
            begin
                // new task becomes the head
                rwr_en         = 1'b1;
                rlen_next      = rlen_reg + RCNT_W'(1);
                head_id_next   = id_reg;
                head_prio_next = prio_reg;
                state_next     = ENG_DONE;
            end

            ENG_HEAD_LD:
            begin
                head_id_next   = rrd_data.id;
                head_prio_next = rrd_data.prio;
                state_next     = ENG_DONE;
            end

            ENG_DONE:
            begin
                if (result_taken)
                begin
                    state_next = ENG_IDLE;
                end
            end

            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // result record
    always_comb
    begin
        result.status           = status_reg;
        result.running_valid    = (rlen_reg != '0);
        result.running_id       = (rlen_reg != '0) ? head_id_reg : '0;
        result.running_priority = (rlen_reg != '0) ? head_prio_reg : '0;
        result.ready_count      = CNT_OUT_W'(rlen_reg);
        result.waiting_count    = CNT_OUT_W'(wlen_reg);
    end

    assign busy         = (state_reg != ENG_IDLE);
    assign result_valid = (state_reg == ENG_DONE);

endmodule

[hw/rtl/task_ready_wait_queues.sv]
// ----------------------------------------------------------------------------
// task_ready_wait_queues: priority-sorted ready list with a waiting list
// Input transactions add a task or suspend the running task; each returns
// one output transaction with the status and the list state afterward.
//
// Usage:
//   in_valid/in_stall carries action, task_id, task_prio and event_code;
//   out_valid/out_stall carries status, running_valid, running_id,
//   running_priority, ready_count and waiting_count, one per transaction in.
// Sequencing:
//   One transaction is worked on at a time; in_stall is high while busy.
//   A ready-list add walks from the tail: each entry that ranks after the
//   new task (at most READY_DEPTH - 1) is read in ENG_RD and shifted one
//   place in ENG_CMP; the task is written in ENG_CMP, or in ENG_PLACE when
//   it is the new head. A suspend leaving tasks ready visits ENG_HEAD_LD.
// Reset: both lists come up empty; the list memory needs no clearing.
// Stall: a finished result sits in the output register until taken; the
//   next transaction is accepted meanwhile and its result waits in the engine.
// ----------------------------------------------------------------------------
module task_ready_wait_queues
    import trwq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [ID_W-1:0]      task_id,
    input  logic [PRIO_W-1:0]    task_prio,
    input  logic [EV_W-1:0]      event_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic                 running_valid,
    output logic [ID_W-1:0]      running_id,
    output logic [PRIO_W-1:0]    running_priority,
    output logic [CNT_OUT_W-1:0] ready_count,
    output logic [CNT_OUT_W-1:0] waiting_count
);

    logic          busy;
    logic          start;
    logic          eng_valid;
    logic          eng_taken;
    trwq_result_t  eng_result;
    logic          out_valid_reg, out_valid_next;
    trwq_result_t  out_result_reg;

    assign in_stall = busy;
    assign start    = in_valid && !busy;

    // list engine
    trwq_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_action   (action),
        .req_id       (task_id),
        .req_prio     (task_prio),
        .req_ev       (event_code),
        .busy         (busy),
        .result_valid (eng_valid),
        .result_taken (eng_taken),
        .result       (eng_result)
    );

    // output register loads when empty or being drained
    assign eng_taken = eng_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_taken)
        begin
            out_result_reg <= eng_result;
        end
    end

    // output fields
    assign out_valid        = out_valid_reg;
    assign status           = out_result_reg.status;
    assign running_valid    = out_result_reg.running_valid;
    assign running_id       = out_result_reg.running_id;
    assign running_priority = out_result_reg.running_priority;
    assign ready_count      = out_result_reg.ready_count;
    assign waiting_count    = out_result_reg.waiting_count;

endmodule

[tb/task_ready_wait_queues_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_ready_wait_queues_tb: self-checking bench for the ready/wait queues
// Drives add and suspend transactions with random gaps, predicts every
// result from a private copy of both lists and checks each output field.
// ----------------------------------------------------------------------------
module task_ready_wait_queues_tb;
    import trwq_pkg::*;

    typedef struct packed {
        logic              act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [EV_W-1:0]   ev;
    } sched_req_t;

    localparam int TOTAL_REQS  = 1150;
    localparam int DRAIN_CYC   = 40;
    localparam int CALM_START  = 600;
    localparam int CALM_END    = 2600;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 action = ACT_ADD;
    logic [ID_W-1:0]      task_id = '0;
    logic [PRIO_W-1:0]    task_prio = '0;
    logic [EV_W-1:0]      event_code = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic                 running_valid;
    logic [ID_W-1:0]      running_id;
    logic [PRIO_W-1:0]    running_priority;
    logic [CNT_OUT_W-1:0] ready_count;
    logic [CNT_OUT_W-1:0] waiting_count;

    // pending stimulus and expected results
    sched_req_t   req_q[$];
    trwq_result_t sched_res_q[$];
    int           planned_cnt = 0;
    int           accepted_cnt = 0;
    int           checked_cnt = 0;
    int           err_cnt = 0;
    int           status_hits[4] = '{0, 0, 0, 0};
    int           plan_rlen = 0;
    int           plan_wlen = 0;
    int           cyc = 0;
    logic         idling;

    // predicted list contents
    logic [ID_W-1:0]   rdy_id[READY_DEPTH];
    logic [PRIO_W-1:0] rdy_prio[READY_DEPTH];
    int                rdy_len = 0;
    logic [ID_W-1:0]   wt_id[WAIT_DEPTH];
    logic [PRIO_W-1:0] wt_prio[WAIT_DEPTH];
    logic [EV_W-1:0]   wt_ev[WAIT_DEPTH];
    int                wt_len = 0;

    task_ready_wait_queues u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .task_id          (task_id),
        .task_prio        (task_prio),
        .event_code       (event_code),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .running_valid    (running_valid),
        .running_id       (running_id),
        .running_priority (running_priority),
        .ready_count      (ready_count),
        .waiting_count    (waiting_count)
    );

    always #5 clk = ~clk;

    // cycle count and the calm window with no idling
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end
    assign idling = !(cyc >= CALM_START && cyc < CALM_END);

    // push a task onto the front of the waiting list
    function automatic void wait_push(input logic [ID_W-1:0] id,
                                      input logic [PRIO_W-1:0] prio,
                                      input logic [EV_W-1:0] ev);
        for (int k = wt_len; k > 0; k--)
        begin
            wt_id[k]   = wt_id[k-1];
            wt_prio[k] = wt_prio[k-1];
            wt_ev[k]   = wt_ev[k-1];
        end
        wt_id[0]   = id;
        wt_prio[0] = prio;
        wt_ev[0]   = ev;
        wt_len++;
    endfunction

    // apply one transaction to the predicted lists, return the list state
    function automatic trwq_result_t schedule_step(input sched_req_t r);
        trwq_result_t res;
        status_t      st;
        int           pos;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_prio;
        st = ST_OK;
        if (r.act == ACT_ADD)
        begin
            if (r.ev == EV_READY)
            begin
                if (rdy_len >= READY_DEPTH)
                    st = ST_READY_FULL;
                else
                begin
                    // equal priorities keep arrival order
                    pos = 0;
                    while (pos < rdy_len && rdy_prio[pos] <= r.prio)
                        pos++;
                    for (int k = rdy_len; k > pos; k--)
                    begin
                        rdy_id[k]   = rdy_id[k-1];
                        rdy_prio[k] = rdy_prio[k-1];
                    end
                    rdy_id[pos]   = r.id;
                    rdy_prio[pos] = r.prio;
                    rdy_len++;
                end
            end
            else if (wt_len >= WAIT_DEPTH)
                st = ST_WAIT_FULL;
            else
                wait_push(r.id, r.prio, r.ev);
        end
        else
        begin
            if (rdy_len == 0)
                st = ST_NONE_RUNNING;
            else if (wt_len >= WAIT_DEPTH)
                st = ST_WAIT_FULL;
            else
            begin
                head_id   = rdy_id[0];
                head_prio = rdy_prio[0];
                for (int k = 1; k < rdy_len; k++)
                begin
                    rdy_id[k-1]   = rdy_id[k];
                    rdy_prio[k-1] = rdy_prio[k];
                end
                rdy_len--;
                wait_push(head_id, head_prio, r.ev);
            end
        end
        res.status           = st;
        res.running_valid    = (rdy_len > 0);
        res.running_id       = (rdy_len > 0) ? rdy_id[0] : '0;
        res.running_priority = (rdy_len > 0) ? rdy_prio[0] : '0;
        res.ready_count      = CNT_OUT_W'(rdy_len);
        res.waiting_count    = CNT_OUT_W'(wt_len);
        return res;
    endfunction

    // queue a transaction and track the list lengths it leads to
    task automatic plan_req(input logic act, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio, input logic [EV_W-1:0] ev);
        sched_req_t r;
        r.act  = act;
        r.id   = id;
        r.prio = prio;
        r.ev   = ev;
        req_q.push_back(r);
        planned_cnt++;
        if (act == ACT_ADD)
        begin
            if (ev == EV_READY)
            begin
                if (plan_rlen < READY_DEPTH)
                    plan_rlen++;
            end
            else if (plan_wlen < WAIT_DEPTH)
                plan_wlen++;
        end
        else if (plan_rlen > 0 && plan_wlen < WAIT_DEPTH)
        begin
            plan_rlen--;
            plan_wlen++;
        end
    endtask

    // priorities crowd into a few values half the time to force ties
    function automatic logic [PRIO_W-1:0] rand_prio();
        if ($urandom_range(1) == 0)
            return PRIO_W'($urandom_range(3));
        return PRIO_W'($urandom);
    endfunction

    function automatic logic [EV_W-1:0] rand_wait_ev();
        return EV_W'($urandom_range(255, 1));
    endfunction

    task automatic plan_noise();
        plan_req(1'($urandom), ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
    endtask

    // input driver: presents queued transactions, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        sched_req_t cur;
        sched_req_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= ACT_ADD;
            task_id    <= '0;
            task_prio  <= '0;
            event_code <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cur.act  = action;
                cur.id   = task_id;
                cur.prio = task_prio;
                cur.ev   = event_code;
                sched_res_q.push_back(schedule_step(cur));
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() > 0 && !(idling && $urandom_range(99) < 34))
                begin
                    nxt = req_q.pop_front();
                    in_valid   <= 1'b1;
                    action     <= nxt.act;
                    task_id    <= nxt.id;
                    task_prio  <= nxt.prio;
                    event_code <= nxt.ev;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // output monitor: random stall, checks each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : watch_res
        trwq_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sched_res_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, status);
                    err_cnt++;
                end
                else
                begin
                    want = sched_res_q.pop_front();
                    check_field("status", 8'(want.status), 8'(status));
                    check_field("running_valid", 8'(want.running_valid), 8'(running_valid));
                    check_field("running_id", want.running_id, running_id);
                    check_field("running_priority", want.running_priority,
                                running_priority);
                    check_field("ready_count", 8'(want.ready_count), 8'(ready_count));
                    check_field("waiting_count", 8'(want.waiting_count),
                                8'(waiting_count));
                    if (!$isunknown(status))
                        status_hits[status]++;
                    checked_cnt++;
                end
            end
            out_stall <= idling && ($urandom_range(99) < 34);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int pick;

        // directed: empty suspend, field extremes, ties, event 0 suspend
        plan_req(ACT_SUSPEND, 8'h00, 8'h00, 8'h5A);
        plan_req(ACT_ADD, 8'hFF, 8'hFF, EV_READY);
        plan_req(ACT_ADD, 8'h00, 8'h00, EV_READY);
        plan_req(ACT_ADD, 8'h01, 8'h00, EV_READY);
        plan_req(ACT_ADD, 8'h80, 8'h80, EV_READY);
        plan_req(ACT_ADD, 8'h7F, 8'hFF, EV_READY);
        plan_req(ACT_ADD, 8'hAA, 8'h55, 8'hFF);
        plan_req(ACT_ADD, 8'h55, 8'hAA, 8'h01);
        plan_req(ACT_SUSPEND, 8'hFF, 8'hFF, EV_READY);
        plan_req(ACT_SUSPEND, 8'h00, 8'h00, 8'hFF);
        plan_req(ACT_ADD, 8'h33, 8'h01, EV_READY);
        plan_req(ACT_SUSPEND, 8'h12, 8'h34, 8'h80);

        // random mix that fills the waiting list just as the ready list empties
        while (plan_wlen < WAIT_DEPTH)
        begin
            pick = $urandom_range(99);
            if (plan_rlen + plan_wlen >= WAIT_DEPTH)
                plan_req(ACT_SUSPEND, ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
            else if (pick < 10)
                plan_noise();
            else if (pick < 55)
                plan_req(ACT_ADD, ID_W'($urandom), rand_prio(), EV_READY);
            else if (pick < 75)
                plan_req(ACT_ADD, ID_W'($urandom), PRIO_W'($urandom), rand_wait_ev());
            else
                plan_req(ACT_SUSPEND, ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
        end

        // empty ready list with full waiting list, then fill the ready list
        plan_req(ACT_SUSPEND, ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
        plan_req(ACT_ADD, ID_W'($urandom), PRIO_W'($urandom), rand_wait_ev());
        while (plan_rlen < READY_DEPTH)
            plan_req(ACT_ADD, ID_W'($urandom), rand_prio(), EV_READY);
        plan_req(ACT_ADD, ID_W'($urandom), rand_prio(), EV_READY);
        plan_req(ACT_ADD, 8'hFF, 8'h00, EV_READY);
        plan_req(ACT_SUSPEND, ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
        plan_req(ACT_ADD, ID_W'($urandom), PRIO_W'($urandom), rand_wait_ev());

        // random traffic against the full lists
        while (planned_cnt < TOTAL_REQS)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                plan_req(ACT_ADD, ID_W'($urandom), rand_prio(), EV_READY);
            else if (pick < 60)
                plan_req(ACT_ADD, ID_W'($urandom), PRIO_W'($urandom), rand_wait_ev());
            else if (pick < 80)
                plan_req(ACT_SUSPEND, ID_W'($urandom), PRIO_W'($urandom), EV_W'($urandom));
            else
                plan_noise();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < planned_cnt)
            @(posedge clk);
        while (sched_res_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("checked %0d transactions, %0d mismatches", checked_cnt, err_cnt);
        $display("status seen: ok %0d, ready full %0d, waiting full %0d, nothing running %0d",
                 status_hits[ST_OK], status_hits[ST_READY_FULL],
                 status_hits[ST_WAIT_FULL], status_hits[ST_NONE_RUNNING]);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("timeout after %0d of %0d transactions", accepted_cnt, planned_cnt);
        $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/trwq_pkg.sv
hw/rtl/trwq_ram.sv
hw/rtl/trwq_engine.sv
hw/rtl/task_ready_wait_queues.sv
tb/task_ready_wait_queues_tb.sv
